// File: hdl/cpds_pkg.sv
package cpds_pkg;

  // Serial multiply-accumulate unit geometry
  localparam int OPND_W = 32;              // signed operand width
  localparam int MUL_W  = 25;              // multiplier (gain sum) width
  localparam int HI_W   = OPND_W + 2;      // running upper partial sum
  localparam int STEPS  = MUL_W;           // one multiplier bit per cycle
  localparam int CNT_W  = $clog2(STEPS);
  localparam int WIDE_W = 40;              // accumulator update width

  localparam int PHASE_COUNT = 2;

  localparam logic [23:0] SPEED_KP_RESET     = 24'd2516582;
  localparam logic [23:0] SPEED_KI_T_RESET   = 24'd5033;
  localparam logic [23:0] CURRENT_KP_RESET   = 24'd2516582;
  localparam logic [23:0] CURRENT_KI_T_RESET = 24'd5033;
  localparam logic [15:0] SETPOINT_RESET     = 16'd0;
  localparam logic [15:0] DUTY_STEP_RESET    = 16'd66;
  localparam logic [15:0] PWM_PERIOD_RESET   = 16'd8500;
  localparam logic [15:0] DUTY_RESET         = 16'h8000;

  typedef enum logic [1:0] {
    OP_SPEED   = 2'd0,
    OP_CURRENT = 2'd1,
    OP_SLEW    = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    REG_SPEED_KP       = 3'd0,
    REG_SPEED_KI_T     = 3'd1,
    REG_CURRENT_KP     = 3'd2,
    REG_CURRENT_KI_T   = 3'd3,
    REG_SPEED_SETPOINT = 3'd4,
    REG_DUTY_STEP      = 3'd5,
    REG_PWM_PERIOD     = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic                     start;
    logic signed [OPND_W-1:0] x;
    logic signed [OPND_W-1:0] y;
    logic        [MUL_W-1:0]  mx;
    logic        [MUL_W-1:0]  my;
  } mac_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic signed [HI_W-1:0] hi;
    logic        [MUL_W-1:0] lo;
  } mac_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(WIDE_W'(32'h7fff_ffff))) begin
      r = 32'sh7fff_ffff;
    end else if (v < -$signed(WIDE_W'(33'h0_8000_0000))) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/cpds_serial_mac.sv
module cpds_serial_mac (
  input  logic               clk,
  input  logic               rst,
  input  cpds_pkg::mac_req_t req,
  output cpds_pkg::mac_rsp_t rsp
);
  import cpds_pkg::*;

  // Computes sum over i of 2^i * (mx[i]*x - my[i]*y), one multiplier bit a cycle,
  // LSB first; the product leaves as {hi, lo}.
  logic signed [OPND_W-1:0] x;
  logic signed [OPND_W-1:0] y;
  logic        [MUL_W-1:0]  mx;
  logic        [MUL_W-1:0]  my;
  logic signed [HI_W-1:0]   hi;
  logic        [MUL_W-1:0]  lo;
  logic        [CNT_W-1:0]  cnt;
  logic                     busy;
  logic                     done;

  logic signed [HI_W-1:0] term_x;
  logic signed [HI_W-1:0] term_y;
  logic signed [HI_W-1:0] term;
  logic signed [HI_W:0]   sum;

  always_comb begin
    term_x = mx[0] ? HI_W'(x) : '0;
    term_y = my[0] ? HI_W'(y) : '0;
    term   = term_x - term_y;
    sum    = (HI_W+1)'(hi) + (HI_W+1)'(term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x  <= req.x;
      y  <= req.y;
      mx <= req.mx;
      my <= req.my;
      hi <= '0;
      lo <= '0;
    end else if (busy) begin
      // shift the finished low bit out into lo
      hi <= sum[HI_W:1];
      lo <= {sum[0], lo[MUL_W-1:1]};
      mx <= mx >> 1;
      my <= my >> 1;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.hi   = hi;
  assign rsp.lo   = lo;

endmodule

// File: hdl/cascaded_pi_duty_slew_unit.sv
// Cascaded PI controller (speed loop feeding a current loop) with a duty slew limiter.
//
// Input stream s_axis_*: one transaction is one control tick. s_axis_tuser carries the
// tick kind (speed, current, slew; the unused code only reports), s_axis_tdata the
// encoder count and two phase-current samples.
// Output stream m_axis_*: exactly one result per tick, showing the state after it:
// current reference, duty goal, applied duty, the two PWM compare values and at_goal.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write the gains, the speed
// setpoint, the duty step and the PWM period; cfg_ready is always high. Write only
// while no tick is in flight.
// Each multiply goes through one shared bit-serial unit, one gain bit per cycle; a speed
// tick needs three such passes, a current tick two, the others one (compare values).
// One tick is worked on at a time; the next is taken once the result is in the output
// register, so a stalled receiver holds back at most one further tick.
// Reset clears the loop state, sets both duty values to half scale and loads the
// default gains; the output register is emptied.
module cascaded_pi_duty_slew_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // encoder_count[15:0], phase_current_a[27:16], phase_current_b[39:28]
  input  logic [39:0]   s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // current_reference[31:0], duty_target[47:32], duty_applied[63:48],
  // compare_high[79:64], compare_low[95:80], at_goal[96], zero[103:97]
  output logic [103:0]  m_axis_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [23:0]   cfg_data
);
  import cpds_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DISPATCH = 11'b000_0000_0010,
    S_SPD_WAIT = 11'b000_0000_0100,
    S_SPD_FIN  = 11'b000_0000_1000,
    S_CUR_SET  = 11'b000_0001_0000,
    S_CUR_WAIT = 11'b000_0010_0000,
    S_CUR_FIN  = 11'b000_0100_0000,
    S_SLEW     = 11'b000_1000_0000,
    S_CMP_SET  = 11'b001_0000_0000,
    S_CMP_WAIT = 11'b010_0000_0000,
    S_CMP_FIN  = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration
  logic [23:0] speed_kp;
  logic [23:0] speed_ki_t;
  logic [23:0] current_kp;
  logic [23:0] current_ki_t;
  logic [15:0] speed_setpoint;
  logic [15:0] duty_step;
  logic [15:0] pwm_period;

  // latched tick
  opcode_t     op;
  logic [15:0] enc;
  logic [11:0] ia;
  logic [11:0] ib;

  // loop state
  logic signed [16:0] spd_eprev;
  logic signed [31:0] spd_acc;
  logic signed [31:0] cur_eprev;
  logic signed [31:0] cur_acc;
  logic signed [31:0] cur_err;
  logic        [15:0] duty_goal;
  logic        [15:0] duty_now;

  mac_req_t mac_req;
  mac_rsp_t mac_rsp;

  cpds_serial_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mac_req),
    .rsp (mac_rsp)
  );

  logic signed [16:0]       spd_err;
  logic        [12:0]       phase_sum;
  logic signed [WIDE_W-1:0] cur_err_wide;
  logic signed [31:0]       cur_err_new;
  logic signed [WIDE_W-1:0] hi_wide;
  logic        [MUL_W:0]    spd_rnd_sum;
  logic        [MUL_W:0]    cur_rnd_sum;
  logic signed [WIDE_W-1:0] spd_inc;
  logic signed [WIDE_W-1:0] cur_inc;
  logic signed [31:0]       spd_acc_next;
  logic signed [31:0]       cur_acc_next;
  logic        [15:0]       duty_goal_next;
  logic signed [16:0]       slew_delta;
  logic signed [16:0]       slew_step;
  logic        [15:0]       duty_now_next;
  logic        [15:0]       cmp_high;
  logic        [15:0]       cmp_low;

  always_comb begin
    spd_err   = $signed({1'b0, speed_setpoint}) - $signed({1'b0, enc});
    phase_sum = {1'b0, ia} + ((PHASE_COUNT >= 2) ? {1'b0, ib} : 13'd0);
    cur_err_wide = WIDE_W'(spd_acc) - $signed({{(WIDE_W-29){1'b0}}, phase_sum, 16'd0});
    cur_err_new  = sat32(cur_err_wide);

    // round half up: add half an LSB of the dropped part, keep the carry
    hi_wide     = WIDE_W'(mac_rsp.hi);
    spd_rnd_sum = {1'b0, mac_rsp.lo} + (MUL_W+1)'(128);
    cur_rnd_sum = {1'b0, mac_rsp.lo} + (MUL_W+1)'(1 << 23);
    spd_inc = (hi_wide <<< (MUL_W - 8))
            + $signed({{(WIDE_W-18){1'b0}}, spd_rnd_sum[MUL_W:8]});
    cur_inc = (hi_wide <<< (MUL_W - 24))
            + $signed({{(WIDE_W-2){1'b0}}, cur_rnd_sum[MUL_W:24]});
    spd_acc_next = sat32(WIDE_W'(spd_acc) + spd_inc);
    cur_acc_next = sat32(WIDE_W'(cur_acc) + cur_inc);

    if (cur_acc_next[31]) begin
      duty_goal_next = 16'd0;
    end else if (|cur_acc_next[30:16]) begin
      duty_goal_next = 16'hffff;
    end else begin
      duty_goal_next = cur_acc_next[15:0];
    end

    slew_delta = $signed({1'b0, duty_goal}) - $signed({1'b0, duty_now});
    slew_step  = $signed({1'b0, duty_step});
    if (slew_delta > slew_step) begin
      duty_now_next = duty_now + duty_step;
    end else if (slew_delta < -slew_step) begin
      duty_now_next = duty_now - duty_step;
    end else begin
      duty_now_next = duty_goal;
    end

    // period * duty: high half is channel one, the complement rounded down channel two
    cmp_high = {mac_rsp.hi[6:0], mac_rsp.lo[24:16]};
    cmp_low  = pwm_period - cmp_high - {15'd0, |mac_rsp.lo[15:0]};
  end

  always_comb begin
    mac_req.start = 1'b0;
    mac_req.x     = '0;
    mac_req.y     = '0;
    mac_req.mx    = '0;
    mac_req.my    = '0;
    case (state)
      S_DISPATCH: begin
        mac_req.start = (op == OP_SPEED);
        mac_req.x     = OPND_W'(spd_err);
        mac_req.y     = OPND_W'(spd_eprev);
        mac_req.mx    = {1'b0, speed_kp} + {1'b0, speed_ki_t};
        mac_req.my    = {1'b0, speed_kp};
      end
      S_CUR_SET: begin
        mac_req.start = 1'b1;
        mac_req.x     = cur_err_new;
        mac_req.y     = cur_eprev;
        mac_req.mx    = {1'b0, current_kp} + {1'b0, current_ki_t};
        mac_req.my    = {1'b0, current_kp};
      end
      S_CMP_SET: begin
        mac_req.start = 1'b1;
        mac_req.x     = $signed({16'd0, pwm_period});
        mac_req.mx    = {{(MUL_W-16){1'b0}}, duty_now};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (op)
          OP_SPEED:   state_next = S_SPD_WAIT;
          OP_CURRENT: state_next = S_CUR_SET;
          OP_SLEW:    state_next = S_SLEW;
          default:    state_next = S_CMP_SET;
        endcase
      end
      S_SPD_WAIT: begin
        if (mac_rsp.done) state_next = S_SPD_FIN;
      end
      S_SPD_FIN:  state_next = S_CUR_SET;
      S_CUR_SET:  state_next = S_CUR_WAIT;
      S_CUR_WAIT: begin
        if (mac_rsp.done) state_next = S_CUR_FIN;
      end
      S_CUR_FIN:  state_next = S_CMP_SET;
      S_SLEW:     state_next = S_CMP_SET;
      S_CMP_SET:  state_next = S_CMP_WAIT;
      S_CMP_WAIT: begin
        if (mac_rsp.done) state_next = S_CMP_FIN;
      end
      S_CMP_FIN: begin
        // hold until the output register is free
        if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_axis_tvalid  <= 1'b0;
      speed_kp       <= SPEED_KP_RESET;
      speed_ki_t     <= SPEED_KI_T_RESET;
      current_kp     <= CURRENT_KP_RESET;
      current_ki_t   <= CURRENT_KI_T_RESET;
      speed_setpoint <= SETPOINT_RESET;
      duty_step      <= DUTY_STEP_RESET;
      pwm_period     <= PWM_PERIOD_RESET;
      spd_eprev      <= '0;
      spd_acc        <= '0;
      cur_eprev      <= '0;
      cur_acc        <= '0;
      duty_goal      <= DUTY_RESET;
      duty_now       <= DUTY_RESET;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        case (cfg_index)
          REG_SPEED_KP:       speed_kp       <= cfg_data;
          REG_SPEED_KI_T:     speed_ki_t     <= cfg_data;
          REG_CURRENT_KP:     current_kp     <= cfg_data;
          REG_CURRENT_KI_T:   current_ki_t   <= cfg_data;
          REG_SPEED_SETPOINT: speed_setpoint <= cfg_data[15:0];
          REG_DUTY_STEP:      duty_step      <= cfg_data[15:0];
          REG_PWM_PERIOD:     pwm_period     <= cfg_data[15:0];
          default: begin
          end
        endcase
      end

      if (state == S_SPD_FIN) begin
        spd_acc   <= spd_acc_next;
        spd_eprev <= spd_err;
      end
      if (state == S_CUR_FIN) begin
        cur_acc   <= cur_acc_next;
        cur_eprev <= cur_err;
        duty_goal <= duty_goal_next;
      end
      if (state == S_SLEW) begin
        duty_now <= duty_now_next;
      end

      if (state == S_CMP_FIN && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op  <= opcode_t'(s_axis_tuser);
      enc <= s_axis_tdata[15:0];
      ia  <= s_axis_tdata[27:16];
      ib  <= s_axis_tdata[39:28];
    end
    if (state == S_CUR_SET) begin
      cur_err <= cur_err_new;
    end
    if (state == S_CMP_FIN && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {7'd0, (duty_now == duty_goal), cmp_low, cmp_high,
                       duty_now, duty_goal, spd_acc};
    end
  end

  // a tick in progress blocks the input
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second tick accepted while one is in progress");

  // the multiplier only finishes where the sequencer waits for it
  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    mac_rsp.done |-> (state == S_SPD_WAIT || state == S_CUR_WAIT || state == S_CMP_WAIT))
    else $error("multiplier result arrived outside a wait state");

  // no multiply may start over one still running
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    mac_req.start |-> !mac_rsp.busy)
    else $error("multiplier restarted while busy");

  a_at_goal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[96] == (m_axis_tdata[63:48] == m_axis_tdata[47:32])))
    else $error("at_goal flag disagrees with duty values");

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cpds_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int RAND_PHASES     = 7;
  localparam int ITEMS_PER_PHASE = 145;
  localparam int HOLD_AT         = 300;
  localparam int HOLD_CYCLES     = 600;

  // lowest field in the lowest bits, matching m_axis_tdata[96:0]
  typedef struct packed {
    logic               at_goal;
    logic [15:0]        compare_low;
    logic [15:0]        compare_high;
    logic [15:0]        duty_applied;
    logic [15:0]        duty_target;
    logic signed [31:0] current_reference;
  } tick_result_t;

  typedef enum logic [1:0] {ROW_TICK, ROW_PINNED, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [1:0]   op;
    logic [15:0]  cnt;
    logic [11:0]  ia;
    logic [11:0]  ib;
    reg_index_t   reg_idx;
    logic [23:0]  reg_val;
    tick_result_t pinned;
  } directed_row_t;

  typedef enum int {READY_FREE, READY_RANDOM, READY_TOGGLE} ready_pattern_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [23:0]  cfg_data;

  // hand-typed expectation travelling with the tick currently offered
  logic         pinned_valid;
  tick_result_t pinned_value;

  tick_result_t results_due[$];
  int           ticks_reported;
  int           mismatch_count;

  // controller copy: configuration
  logic [23:0] spd_kp, spd_ki_t, cur_kp, cur_ki_t;
  logic [15:0] spd_setpoint, duty_step, pwm_period;
  // controller copy: loop state
  logic signed [16:0] spd_err_prev;
  logic signed [31:0] spd_acc, cur_err_prev, cur_acc;
  logic [15:0]        duty_goal, duty_now;

  cascaded_pi_duty_slew_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > longint'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (v < -longint'(33'h0_8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void run_current_loop(input logic [11:0] ia, input logic [11:0] ib);
    longint phase_sum;
    longint prod;
    logic signed [31:0] err;
    phase_sum = longint'(ia) + ((PHASE_COUNT >= 2) ? longint'(ib) : 64'sd0);
    err = clamp32(longint'(spd_acc) - phase_sum * 65536);
    prod = (longint'(cur_kp) + longint'(cur_ki_t)) * longint'(err)
         - longint'(cur_kp) * longint'(cur_err_prev);
    // round half up from Q24 to Q16.16
    cur_acc = clamp32(longint'(cur_acc) + ((prod + (64'sd1 <<< 23)) >>> 24));
    cur_err_prev = err;
    if (cur_acc < 0) begin
      duty_goal = 16'd0;
    end else if (cur_acc > 32'sd65535) begin
      duty_goal = 16'hFFFF;
    end else begin
      duty_goal = cur_acc[15:0];
    end
  endfunction

  function automatic tick_result_t run_control_tick(input logic [1:0] op,
                                                    input logic [15:0] cnt,
                                                    input logic [11:0] ia,
                                                    input logic [11:0] ib);
    longint err;
    longint prod;
    int delta;
    int step;
    tick_result_t r;
    case (op)
      OP_SPEED: begin
        err = longint'(spd_setpoint) - longint'(cnt);
        prod = (longint'(spd_kp) + longint'(spd_ki_t)) * err
             - longint'(spd_kp) * longint'(spd_err_prev);
        spd_acc = clamp32(longint'(spd_acc) + ((prod + 64'sd128) >>> 8));
        spd_err_prev = err[16:0];
        run_current_loop(ia, ib);
      end
      OP_CURRENT: begin
        run_current_loop(ia, ib);
      end
      OP_SLEW: begin
        delta = int'(duty_goal) - int'(duty_now);
        step = int'(duty_step);
        if (delta > step) begin
          duty_now = duty_now + duty_step;
        end else if (delta < -step) begin
          duty_now = duty_now - duty_step;
        end else begin
          duty_now = duty_goal;
        end
      end
      default: ;
    endcase
    r.current_reference = spd_acc;
    r.duty_target = duty_goal;
    r.duty_applied = duty_now;
    r.compare_high = 16'((longint'(pwm_period) * longint'(duty_now)) >>> 16);
    r.compare_low = 16'((longint'(pwm_period) * (64'sd65536 - longint'(duty_now))) >>> 16);
    r.at_goal = (duty_now == duty_goal);
    return r;
  endfunction

  // Sample both streams and the register port on the rising edge
  always @(posedge clk) begin : monitor
    tick_result_t got;
    tick_result_t want;
    if (rst) begin
      spd_kp = SPEED_KP_RESET;
      spd_ki_t = SPEED_KI_T_RESET;
      cur_kp = CURRENT_KP_RESET;
      cur_ki_t = CURRENT_KI_T_RESET;
      spd_setpoint = SETPOINT_RESET;
      duty_step = DUTY_STEP_RESET;
      pwm_period = PWM_PERIOD_RESET;
      spd_err_prev = '0;
      spd_acc = '0;
      cur_err_prev = '0;
      cur_acc = '0;
      duty_goal = DUTY_RESET;
      duty_now = DUTY_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPEED_KP:       spd_kp = cfg_data;
          REG_SPEED_KI_T:     spd_ki_t = cfg_data;
          REG_CURRENT_KP:     cur_kp = cfg_data;
          REG_CURRENT_KI_T:   cur_ki_t = cfg_data;
          REG_SPEED_SETPOINT: spd_setpoint = cfg_data[15:0];
          REG_DUTY_STEP:      duty_step = cfg_data[15:0];
          REG_PWM_PERIOD:     pwm_period = cfg_data[15:0];
          default: ;
        endcase
      end
      // check the output before queueing: a result never belongs to the tick taken at this edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[96:0];
        ticks_reported++;
        if (results_due.size() == 0) begin
          $error("result with nothing outstanding: %h", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          if (got.current_reference !== want.current_reference) begin
            $error("current_reference expected %0d got %0d",
                   want.current_reference, got.current_reference);
            mismatch_count++;
          end
          if (got.duty_target !== want.duty_target) begin
            $error("duty_target expected %0d got %0d", want.duty_target, got.duty_target);
            mismatch_count++;
          end
          if (got.duty_applied !== want.duty_applied) begin
            $error("duty_applied expected %0d got %0d", want.duty_applied, got.duty_applied);
            mismatch_count++;
          end
          if (got.compare_high !== want.compare_high) begin
            $error("compare_high expected %0d got %0d", want.compare_high, got.compare_high);
            mismatch_count++;
          end
          if (got.compare_low !== want.compare_low) begin
            $error("compare_low expected %0d got %0d", want.compare_low, got.compare_low);
            mismatch_count++;
          end
          if (got.at_goal !== want.at_goal) begin
            $error("at_goal expected %0d got %0d", want.at_goal, got.at_goal);
            mismatch_count++;
          end
          if (m_axis_tdata[103:97] !== '0) begin
            $error("tdata padding expected 0 got %h", m_axis_tdata[103:97]);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = run_control_tick(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[27:16],
                                s_axis_tdata[39:28]);
        results_due.push_back(pinned_valid ? pinned_value : want);
      end
    end
  end

  function automatic directed_row_t tick_row(input logic [1:0] op, input logic [15:0] cnt,
                                             input logic [11:0] ia, input logic [11:0] ib);
    directed_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.op = op;
    r.cnt = cnt;
    r.ia = ia;
    r.ib = ib;
    return r;
  endfunction

  function automatic directed_row_t pinned_row(input logic [1:0] op, input logic [15:0] cnt,
                                               input logic [11:0] ia, input logic [11:0] ib,
                                               input tick_result_t res);
    directed_row_t r;
    r = tick_row(op, cnt, ia, ib);
    r.kind = ROW_PINNED;
    r.pinned = res;
    return r;
  endfunction

  function automatic directed_row_t cfg_row(input reg_index_t idx, input logic [23:0] val);
    directed_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [23:0] random_gain();
    int k;
    k = $urandom_range(0, 24);
    return 24'($urandom & ((32'd1 << k) - 32'd1));
  endfunction

  task automatic send_tick(input logic [1:0] op, input logic [15:0] cnt, input logic [11:0] ia,
                           input logic [11:0] ib, input logic pin, input tick_result_t pin_val);
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {ib, ia, cnt};
    pinned_valid = pin;
    pinned_value = pin_val;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic hold_sender(input int gap);
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      pinned_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    pinned_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : stimulus
    directed_row_t directed_rows[$];
    tick_result_t  at_reset;
    tick_result_t  goal_zero;
    logic [23:0]   reg_vals[7];
    logic [1:0]    op;
    logic [15:0]   cnt;
    logic [11:0]   ia;
    logic [11:0]   ib;
    int            pick;
    int            span;
    int            left;
    int            burst;
    int            gap;

    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SPEED_KP;
    cfg_data = '0;
    pinned_valid = 1'b0;
    pinned_value = '0;
    ticks_reported = 0;
    mismatch_count = 0;

    at_reset = '{at_goal: 1'b1, compare_low: 16'd4250, compare_high: 16'd4250,
                 duty_applied: DUTY_RESET, duty_target: DUTY_RESET, current_reference: 32'sd0};
    goal_zero = at_reset;
    goal_zero.duty_target = 16'd0;
    goal_zero.at_goal = 1'b0;

    directed_rows = {
      pinned_row(OP_UNUSED, 16'hFFFF, 12'hFFF, 12'hFFF, at_reset),
      pinned_row(OP_SLEW, 16'h0000, 12'h000, 12'h000, at_reset),
      pinned_row(OP_SPEED, 16'h0000, 12'h000, 12'h000, goal_zero),
      tick_row(OP_SLEW, 16'h0000, 12'h000, 12'h000),
      tick_row(OP_CURRENT, 16'h0000, 12'hFFF, 12'hFFF),
      tick_row(OP_SPEED, 16'hFFFF, 12'h0F0, 12'hA5A),
      tick_row(OP_SPEED, 16'h0000, 12'h555, 12'hAAA),
      cfg_row(REG_SPEED_SETPOINT, 24'h00FFFF),
      tick_row(OP_SPEED, 16'h0000, 12'h000, 12'h000),
      tick_row(OP_SPEED, 16'h0000, 12'h000, 12'h000),
      cfg_row(REG_DUTY_STEP, 24'h00FFFF),
      tick_row(OP_SLEW, 16'h0000, 12'h000, 12'h000),
      cfg_row(REG_DUTY_STEP, 24'h000000),
      tick_row(OP_CURRENT, 16'h0000, 12'hFFF, 12'h000),
      tick_row(OP_SLEW, 16'h0000, 12'h000, 12'h000),
      cfg_row(REG_PWM_PERIOD, 24'h000000),
      tick_row(OP_UNUSED, 16'h1234, 12'h000, 12'h000),
      tick_row(OP_SLEW, 16'h0000, 12'h000, 12'h000),
      cfg_row(REG_PWM_PERIOD, 24'h00FFFF),
      cfg_row(REG_SPEED_KP, 24'hFFFFFF),
      cfg_row(REG_SPEED_KI_T, 24'hFFFFFF),
      tick_row(OP_SPEED, 16'h8000, 12'h000, 12'h000),
      tick_row(OP_SPEED, 16'h0000, 12'h000, 12'h000),
      tick_row(OP_SLEW, 16'h0000, 12'h000, 12'h000)
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_tick(directed_rows[i].op, directed_rows[i].cnt, directed_rows[i].ia,
                  directed_rows[i].ib, directed_rows[i].kind == ROW_PINNED,
                  directed_rows[i].pinned);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) begin
        reg_vals[REG_SPEED_KP] = 24'hFFFFFF;
        reg_vals[REG_SPEED_KI_T] = 24'hFFFFFF;
        reg_vals[REG_CURRENT_KP] = 24'hFFFFFF;
        reg_vals[REG_CURRENT_KI_T] = 24'hFFFFFF;
        reg_vals[REG_SPEED_SETPOINT] = 24'h00FFFF;
        reg_vals[REG_DUTY_STEP] = 24'h00FFFF;
        reg_vals[REG_PWM_PERIOD] = 24'h00FFFF;
      end else if (p == 1) begin
        reg_vals[REG_SPEED_KP] = '0;
        reg_vals[REG_SPEED_KI_T] = '0;
        reg_vals[REG_CURRENT_KP] = '0;
        reg_vals[REG_CURRENT_KI_T] = '0;
        reg_vals[REG_SPEED_SETPOINT] = '0;
        reg_vals[REG_DUTY_STEP] = '0;
        reg_vals[REG_PWM_PERIOD] = 24'd1;
      end else begin
        reg_vals[REG_SPEED_KP] = random_gain();
        reg_vals[REG_SPEED_KI_T] = random_gain();
        reg_vals[REG_CURRENT_KP] = random_gain();
        reg_vals[REG_CURRENT_KI_T] = random_gain();
        reg_vals[REG_SPEED_SETPOINT] = 24'($urandom_range(0, 65535));
        reg_vals[REG_DUTY_STEP] = random_gain() & 24'h00FFFF;
        reg_vals[REG_PWM_PERIOD] = 24'($urandom_range(1, 65535));
      end
      drain();
      for (int r = REG_SPEED_KP; r <= REG_PWM_PERIOD; r++) begin
        write_reg(reg_index_t'(r), reg_vals[r]);
      end

      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        burst = $urandom_range(1, 16);
        while (burst > 0 && left > 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 35) op = OP_SPEED;
          else if (pick < 65) op = OP_CURRENT;
          else if (pick < 95) op = OP_SLEW;
          else op = OP_UNUSED;
          // mostly track the setpoint so the speed loop stays out of saturation
          if ($urandom_range(0, 9) < 7) begin
            span = 1 << $urandom_range(0, 8);
            cnt = 16'(int'(reg_vals[REG_SPEED_SETPOINT]) + $urandom_range(0, 2 * span) - span);
          end else begin
            cnt = 16'($urandom);
          end
          ia = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 31));
          ib = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 31));
          send_tick(op, cnt, ia, ib, 1'b0, '0);
          burst--;
          left--;
        end
        pick = $urandom_range(0, 3);
        if (pick == 0) gap = 0;
        else if (pick == 3) gap = $urandom_range(13, 100);
        else gap = $urandom_range(1, 12);
        hold_sender(gap);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[cascaded_pi_duty_slew_unit] OK");
    end else begin
      $display("[cascaded_pi_duty_slew_unit] ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int             seg_len;
    ready_pattern_t pattern;
    bit             held;
    m_axis_tready = 1'b0;
    held = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      // one long hold-off so the unit fills up and backs up its input
      if (!held && ticks_reported >= HOLD_AT) begin
        held = 1'b1;
        @(negedge clk);
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end
      seg_len = $urandom_range(8, 64);
      pattern = ready_pattern_t'($urandom_range(READY_FREE, READY_TOGGLE));
      repeat (seg_len) begin
        @(negedge clk);
        case (pattern)
          READY_FREE:   m_axis_tready = 1'b1;
          READY_RANDOM: m_axis_tready = ($urandom_range(0, 2) != 0);
          default:      m_axis_tready = ~m_axis_tready;
        endcase
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[cascaded_pi_duty_slew_unit] ERROR");
    $finish;
  end

endmodule
